// ----- hdl/pwl_pkg.sv -----
// Shared constants, codes and types of the piecewise linear calibration block.
package pwl_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int MAX_POINTS   = 8;

  // Field widths of the request and result channels.
  localparam int ACT_W  = 2;
  localparam int CH_W   = 3;
  localparam int PIDX_W = 3;
  localparam int AD_W   = 16;
  localparam int VAL_W  = 16;
  localparam int PCNT_W = 4;
  localparam int OUT_W  = 32;
  localparam int STAT_W = 2;

  // Table geometry.
  localparam int TABLE_DEPTH = NUM_CHANNELS * MAX_POINTS;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int WORD_W      = AD_W + VAL_W;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Divider.
  localparam int DIV_STEPS = 32;
  localparam int DSTEP_W   = $clog2(DIV_STEPS);

  // Request actions.
  localparam logic [ACT_W-1:0] ACT_WRITE_POINT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SET_COUNT   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CONVERT     = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_EXACT  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INTERP = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ERROR  = 2'd2;

  // Classified operations passed from front to back.
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_COUNT   = 2'd1;
  localparam logic [1:0] OP_CONVERT = 2'd2;
  localparam logic [1:0] OP_FAULT   = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [CH_W-1:0]   channel;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] point_word;
    logic [CNT_W-1:0]  count;
    logic [AD_W-1:0]   sample;
  } cmd_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

// ----- hdl/pwl_ifs.sv -----
// Request and result channel interfaces of the calibration block.
interface pwl_in_if;
  logic                        valid;
  logic                        ready;
  logic [pwl_pkg::ACT_W-1:0]   action;
  logic [pwl_pkg::CH_W-1:0]    channel;
  logic [pwl_pkg::PIDX_W-1:0]  point_index;
  logic [pwl_pkg::AD_W-1:0]    point_ad;
  logic [pwl_pkg::VAL_W-1:0]   point_value;
  logic [pwl_pkg::PCNT_W-1:0]  point_count;
  logic [pwl_pkg::AD_W-1:0]    ad_sample;

  modport source (
    output valid, action, channel, point_index, point_ad, point_value, point_count,
           ad_sample,
    input  ready
  );
  modport sink (
    input  valid, action, channel, point_index, point_ad, point_value, point_count,
           ad_sample,
    output ready
  );
endinterface

interface pwl_out_if;
  logic                        valid;
  logic                        ready;
  logic [pwl_pkg::OUT_W-1:0]   line_value;
  logic [pwl_pkg::STAT_W-1:0]  status;

  modport source (output valid, line_value, status, input ready);
  modport sink (input valid, line_value, status, output ready);
endinterface

// ----- hdl/pwl_front.sv -----
// Front end: accept requests, classify them and hold one command for the queue.
module pwl_front (
  input  logic          clk,
  input  logic          rst,
  pwl_in_if.sink        req,
  output pwl_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready
);

  logic          keep;
  pwl_pkg::cmd_t cmd_next;
  logic          ch_ok;
  logic          idx_ok;
  logic          cnt_over;

  assign req.ready = !cmd_valid || cmd_ready;

  assign ch_ok    = 32'(req.channel) < pwl_pkg::NUM_CHANNELS;
  assign idx_ok   = 32'(req.point_index) < pwl_pkg::MAX_POINTS;
  assign cnt_over = 32'(req.point_count) > pwl_pkg::MAX_POINTS;

  always_comb begin
    cmd_next.op         = pwl_pkg::OP_FAULT;
    cmd_next.channel    = req.channel;
    cmd_next.addr       = pwl_pkg::ADDR_W'(req.channel) * pwl_pkg::ADDR_W'(pwl_pkg::MAX_POINTS)
                          + pwl_pkg::ADDR_W'(req.point_index);
    cmd_next.point_word = {req.point_value, req.point_ad};
    cmd_next.count      = cnt_over ? '0 : pwl_pkg::CNT_W'(req.point_count);
    cmd_next.sample     = req.ad_sample;
    keep                = 1'b0;
    case (req.action)
      pwl_pkg::ACT_WRITE_POINT: begin
        cmd_next.op = pwl_pkg::OP_WRITE;
        keep        = ch_ok && idx_ok;
      end
      pwl_pkg::ACT_SET_COUNT: begin
        cmd_next.op = pwl_pkg::OP_COUNT;
        keep        = ch_ok;
      end
      pwl_pkg::ACT_CONVERT: begin
        // Out-of-range channel still owes an error result.
        cmd_next.op = ch_ok ? pwl_pkg::OP_CONVERT : pwl_pkg::OP_FAULT;
        keep        = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (req.ready) begin
      cmd_valid <= req.valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd <= cmd_next;
    end
  end

endmodule

// ----- hdl/pwl_queue.sv -----
// Short command queue between front end and back end.
module pwl_queue (
  input  logic          clk,
  input  logic          rst,
  input  pwl_pkg::cmd_t push_data,
  input  logic          push_valid,
  output logic          push_ready,
  output pwl_pkg::cmd_t pop_data,
  output logic          pop_valid,
  input  logic          pop_ready
);

  pwl_pkg::cmd_t                 slots [pwl_pkg::QUEUE_DEPTH];
  logic [pwl_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [pwl_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [pwl_pkg::Q_CNT_W-1:0]   fill;
  logic                          do_push;
  logic                          do_pop;

  localparam logic [pwl_pkg::Q_PTR_W-1:0] LAST_PTR = pwl_pkg::Q_PTR_W'(pwl_pkg::QUEUE_DEPTH - 1);
  localparam logic [pwl_pkg::Q_CNT_W-1:0] FULL_CNT = pwl_pkg::Q_CNT_W'(pwl_pkg::QUEUE_DEPTH);

  assign push_ready = fill != FULL_CNT;
  assign pop_valid  = fill != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- hdl/pwl_div.sv -----
// Restoring divider, one quotient bit per cycle, 32-bit by 16-bit unsigned.
module pwl_div (
  input  logic              clk,
  input  logic              rst,
  input  pwl_pkg::div_req_t req,
  output pwl_pkg::div_rsp_t rsp
);

  logic                         busy;
  logic                         done;
  logic [pwl_pkg::DSTEP_W-1:0]  step;
  logic [15:0]                  divisor;
  logic [15:0]                  rem;
  logic [31:0]                  quo;
  logic [16:0]                  shifted;
  logic                         ge;
  logic [16:0]                  diff;

  localparam logic [pwl_pkg::DSTEP_W-1:0] LAST_STEP = pwl_pkg::DSTEP_W'(pwl_pkg::DIV_STEPS - 1);

  assign shifted = {rem, quo[31]};
  assign ge      = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};
  assign rsp     = {done, quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      rem     <= '0;
      quo     <= req.dividend;
    end else if (busy) begin
      rem <= ge ? diff[15:0] : shifted[15:0];
      quo <= {quo[30:0], ge};
    end
  end

endmodule

// ----- hdl/pwl_back.sv -----
// Back end: point table, point counts, table scan, interpolation and result register.
module pwl_back (
  input  logic          clk,
  input  logic          rst,
  input  pwl_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  pwl_out_if.source     res
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_E0     = 4'd1;
  localparam logic [3:0] S_EH     = 4'd2;
  localparam logic [3:0] S_NXT    = 4'd3;
  localparam logic [3:0] S_PRV    = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_DIFF   = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_DSTART = 4'd8;
  localparam logic [3:0] S_DWAIT  = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  logic [3:0]                         state;
  logic [pwl_pkg::CNT_W-1:0]          counts [pwl_pkg::NUM_CHANNELS];
  logic [pwl_pkg::WORD_W-1:0]         mem [pwl_pkg::TABLE_DEPTH];
  logic [pwl_pkg::WORD_W-1:0]         rdata;
  logic                               mem_we;
  logic [pwl_pkg::ADDR_W-1:0]         raddr;
  logic [pwl_pkg::CH_W-1:0]           ch_sel;
  logic [pwl_pkg::CH_W-1:0]           ch;
  logic [pwl_pkg::AD_W-1:0]           x;
  logic [pwl_pkg::IDX_W-1:0]          hi;
  logic [pwl_pkg::IDX_W-1:0]          lo;
  logic [pwl_pkg::IDX_W-1:0]          lo_inc;
  logic [pwl_pkg::IDX_W-1:0]          rd_idx;
  logic [pwl_pkg::CNT_W-1:0]          n_sel;
  logic [pwl_pkg::WORD_W-1:0]         ent_a;
  logic [pwl_pkg::WORD_W-1:0]         ent_b;
  logic [15:0]                        a_ad;
  logic [15:0]                        a_val;
  logic [15:0]                        b_ad;
  logic [15:0]                        b_val;
  logic [15:0]                        r_ad;
  logic [15:0]                        r_val16;
  logic [16:0]                        d_x;
  logic [16:0]                        d_v;
  logic [16:0]                        d_a;
  logic [15:0]                        mag_x;
  logic [15:0]                        mag_v;
  logic [15:0]                        mag_a;
  logic [15:0]                        v_base;
  logic                               neg;
  logic [31:0]                        prod;
  logic [32:0]                        sum_pos;
  logic [31:0]                        interp_val;
  logic [pwl_pkg::OUT_W-1:0]          r_val;
  logic [pwl_pkg::STAT_W-1:0]         r_stat;
  logic                               out_load;
  logic                               prv_pick;
  pwl_pkg::div_req_t                  div_req;
  pwl_pkg::div_rsp_t                  div_rsp;

  assign cmd_ready = state == S_IDLE;
  assign n_sel     = counts[cmd.channel];
  assign mem_we    = (state == S_IDLE) && cmd_valid && (cmd.op == pwl_pkg::OP_WRITE);

  // Entry fields: ADC value low, true value high.
  assign a_ad    = ent_a[15:0];
  assign a_val   = ent_a[31:16];
  assign b_ad    = ent_b[15:0];
  assign b_val   = ent_b[31:16];
  assign r_ad    = rdata[15:0];
  assign r_val16 = rdata[31:16];
  assign lo_inc  = lo + 1'b1;

  assign prv_pick = !(a_ad > x) && (r_ad < x);

  // Pick the entry read this cycle; its data shows up in rdata next cycle.
  always_comb begin
    case (state)
      S_IDLE:  rd_idx = '0;
      S_E0:    rd_idx = hi;
      S_EH:    rd_idx = prv_pick ? hi - 1'b1 : pwl_pkg::IDX_W'(1);
      S_SCAN:  rd_idx = lo + pwl_pkg::IDX_W'(2);
      default: rd_idx = '0;
    endcase
  end

  assign ch_sel = (state == S_IDLE) ? cmd.channel : ch;
  assign raddr  = pwl_pkg::ADDR_W'(ch_sel) * pwl_pkg::ADDR_W'(pwl_pkg::MAX_POINTS)
                  + pwl_pkg::ADDR_W'(rd_idx);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd.addr] <= cmd.point_word;
    end
    rdata <= mem[raddr];
  end

  // Signed differences of the chosen pair, then magnitudes and sign of the quotient.
  assign d_x   = {1'b0, x} - {1'b0, a_ad};
  assign d_v   = {1'b0, b_val} - {1'b0, a_val};
  assign d_a   = {1'b0, b_ad} - {1'b0, a_ad};

  assign div_req.start    = state == S_DSTART;
  assign div_req.dividend = prod;
  assign div_req.divisor  = mag_a;

  pwl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Add the truncated quotient to the base value, or subtract it and clamp at zero when the sign is negative.
  assign sum_pos = {1'b0, div_rsp.quotient} + 33'(v_base);
  always_comb begin
    if (neg) begin
      interp_val = (div_rsp.quotient > 32'(v_base)) ? '0 : 32'(v_base) - div_rsp.quotient;
    end else begin
      interp_val = sum_pos[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < pwl_pkg::NUM_CHANNELS; i++) begin
        counts[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              pwl_pkg::OP_WRITE: begin
                state <= S_IDLE;
              end
              pwl_pkg::OP_COUNT: begin
                counts[cmd.channel] <= cmd.count;
              end
              pwl_pkg::OP_CONVERT: begin
                ch <= cmd.channel;
                x  <= cmd.sample;
                hi <= pwl_pkg::IDX_W'(n_sel - 1'b1);
                if (n_sel == '0) begin
                  r_val  <= '0;
                  r_stat <= pwl_pkg::STAT_ERROR;
                  state  <= S_EMIT;
                end else begin
                  state <= S_E0;
                end
              end
              default: begin
                r_val  <= '0;
                r_stat <= pwl_pkg::STAT_ERROR;
                state  <= S_EMIT;
              end
            endcase
          end
        end
        S_E0: begin
          if (hi == '0) begin
            // Single point: line through the origin.
            ent_a <= '0;
            ent_b <= rdata;
            state <= S_DIFF;
          end else begin
            ent_a <= rdata;
            state <= S_EH;
          end
        end
        S_EH: begin
          if (a_ad > x) begin
            state <= S_NXT;
          end else if (r_ad < x) begin
            ent_b <= rdata;
            state <= S_PRV;
          end else begin
            lo    <= '0;
            state <= S_SCAN;
          end
        end
        S_NXT: begin
          ent_b <= rdata;
          state <= S_DIFF;
        end
        S_PRV: begin
          ent_a <= rdata;
          state <= S_DIFF;
        end
        S_SCAN: begin
          if (x == a_ad) begin
            r_val  <= 32'(a_val);
            r_stat <= pwl_pkg::STAT_EXACT;
            state  <= S_EMIT;
          end else if (x == r_ad) begin
            r_val  <= 32'(r_val16);
            r_stat <= pwl_pkg::STAT_EXACT;
            state  <= S_EMIT;
          end else if ((x > a_ad) && (x < r_ad)) begin
            ent_b <= rdata;
            state <= S_DIFF;
          end else if (lo_inc == hi) begin
            // No enclosing pair: table out of order.
            r_val  <= '0;
            r_stat <= pwl_pkg::STAT_ERROR;
            state  <= S_EMIT;
          end else begin
            ent_a <= rdata;
            lo    <= lo_inc;
          end
        end
        S_DIFF: begin
          if (d_a == '0) begin
            r_val  <= '0;
            r_stat <= pwl_pkg::STAT_ERROR;
            state  <= S_EMIT;
          end else begin
            mag_x  <= d_x[16] ? ~d_x[15:0] + 16'd1 : d_x[15:0];
            mag_v  <= d_v[16] ? ~d_v[15:0] + 16'd1 : d_v[15:0];
            mag_a  <= d_a[16] ? ~d_a[15:0] + 16'd1 : d_a[15:0];
            neg    <= d_x[16] ^ d_v[16] ^ d_a[16];
            v_base <= a_val;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= 32'(mag_x) * 32'(mag_v);
          state <= S_DSTART;
        end
        S_DSTART: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_rsp.done) begin
            r_val  <= interp_val;
            r_stat <= pwl_pkg::STAT_INTERP;
            state  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register: load when empty or being drained.
  assign out_load = (state == S_EMIT) && (!res.valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.line_value <= r_val;
      res.status     <= r_stat;
    end
  end

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DWAIT)
    else $error("divider finished outside its wait state");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> lo < hi)
    else $error("table scan ran past the last point");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.status != pwl_pkg::STAT_ERROR || res.line_value == '0))
    else $error("error result carries a nonzero value");

  a_emit_fills: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !res.valid) |=> res.valid)
    else $error("pending result not loaded into an empty output register");

endmodule

// ----- hdl/piecewise_linear_calibration.sv -----
// Top level of the per-channel piecewise linear calibration block.
//
// Channels: req (pwl_in_if sink) takes one request per valid/ready handshake.
// Action write point stores a point into a channel table, set point count
// sets the number of points (a count above the table size stores zero), and
// convert sample returns one result on res (pwl_out_if source). Other
// requests give no result and are dropped in the front end.
// Path: a request passes the front register and the two-entry queue before
// the back end takes it. Writes and count updates are done in the back end's
// idle state. A conversion scans the table (one 32-bit table read per cycle
// on a single read port, up to eight points), forms the differences, does
// the 16x16 multiply and the bit-serial divide (start, 32 quotient bits,
// finish) and loads the result register; errors and exact matches skip the
// multiply and divide.
// Flow: the back end handles one conversion at a time; the front keeps
// taking requests until the queue and the front register are both full.
// Reset (rst, synchronous) clears point counts, queue and result register;
// table entries stay undefined until written. A stalled receiver holds the
// result register; the back end waits, and requests back up to req.ready.
module piecewise_linear_calibration (
  input  logic      clk,
  input  logic      rst,
  pwl_in_if.sink    req,
  pwl_out_if.source res
);

  pwl_pkg::cmd_t f_cmd;
  logic          f_valid;
  logic          f_ready;
  pwl_pkg::cmd_t q_cmd;
  logic          q_valid;
  logic          q_ready;

  // Classify requests and hold one command for the queue.
  pwl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (f_cmd),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready)
  );

  // Decouple the front end from a busy back end.
  pwl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (f_cmd),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_data   (q_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  // Execute commands in order: table writes, counts and conversions.
  pwl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (q_cmd),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .res       (res)
  );

endmodule

// ----- tb/tb_piecewise_linear_calibration.sv -----
// Self-checking testbench for the piecewise linear calibration block.
module tb_piecewise_linear_calibration;

  // The fourth action code has no name in the package; the block drops it.
  localparam logic [pwl_pkg::ACT_W-1:0] ACT_RESERVED = 2'd3;

  localparam int     RANDOM_REQUESTS = 800;
  localparam int     CALM_TAIL       = 100;   // last requests run without idling
  localparam int     SETTLE_CYCLES   = 64;    // longest conversion plus margin
  localparam int     WATCHDOG_LIMIT  = 1000;
  localparam longint VALUE_CEIL      = 64'h0000_0000_FFFF_FFFF;

  typedef struct {
    logic [pwl_pkg::ACT_W-1:0]  action;
    logic [pwl_pkg::CH_W-1:0]   channel;
    logic [pwl_pkg::PIDX_W-1:0] point_index;
    logic [pwl_pkg::AD_W-1:0]   point_ad;
    logic [pwl_pkg::VAL_W-1:0]  point_value;
    logic [pwl_pkg::PCNT_W-1:0] point_count;
    logic [pwl_pkg::AD_W-1:0]   ad_sample;
    bit                         drain;     // hold this request until every result is back
  } pwl_request_t;

  typedef struct {
    logic [pwl_pkg::OUT_W-1:0]  line_value;
    logic [pwl_pkg::STAT_W-1:0] status;
  } cal_result_t;

  logic clk;
  logic rst;

  pwl_in_if  req_if ();
  pwl_out_if res_if ();

  piecewise_linear_calibration u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .res (res_if.source)
  );

  // ---------------------------------------------------------------------------
  // Calibration predictor: its own copy of the point tables and point counts,
  // updated as each request is accepted.
  // ---------------------------------------------------------------------------
  logic [pwl_pkg::WORD_W-1:0] cal_points [pwl_pkg::TABLE_DEPTH];
  logic [3:0]                 cal_count  [pwl_pkg::NUM_CHANNELS];
  cal_result_t                conversions_due [$];

  function automatic longint ad_at(int k);
    return longint'(cal_points[k][pwl_pkg::AD_W-1:0]);
  endfunction

  function automatic longint val_at(int k);
    return longint'(cal_points[k][pwl_pkg::WORD_W-1:pwl_pkg::AD_W]);
  endfunction

  // Convert one raw sample of channel ch the way the block should.
  function automatic cal_result_t calibrate(int ch, longint x);
    cal_result_t outcome;
    int          n;
    int          base;
    int          hi;
    int          lo;
    longint      a1, v1, a2, v2, r;
    longint      alo, anx;
    bit          found;
    outcome.line_value = '0;
    outcome.status     = pwl_pkg::STAT_ERROR;
    if (ch >= pwl_pkg::NUM_CHANNELS) return outcome;
    n = int'(cal_count[ch]);
    if (n < 1 || n > pwl_pkg::MAX_POINTS) return outcome;
    base = ch * pwl_pkg::MAX_POINTS;
    hi   = n - 1;
    if (n == 1) begin
      // Single point: the line runs through the origin, no exact match test.
      a1 = 0;
      v1 = 0;
      a2 = ad_at(base);
      v2 = val_at(base);
    end else if (ad_at(base) > x) begin
      // Below the table: extrapolate from the first two points.
      a1 = ad_at(base);
      v1 = val_at(base);
      a2 = ad_at(base + 1);
      v2 = val_at(base + 1);
    end else if (ad_at(base + hi) < x) begin
      // Above the table: extrapolate from the last two points.
      a1 = ad_at(base + hi - 1);
      v1 = val_at(base + hi - 1);
      a2 = ad_at(base + hi);
      v2 = val_at(base + hi);
    end else begin
      found = 1'b0;
      a1 = 0;
      v1 = 0;
      a2 = 0;
      v2 = 0;
      for (lo = 0; lo < hi; lo++) begin
        alo = ad_at(base + lo);
        anx = ad_at(base + lo + 1);
        if (x == alo) begin
          outcome.line_value = pwl_pkg::OUT_W'(val_at(base + lo));
          outcome.status     = pwl_pkg::STAT_EXACT;
          return outcome;
        end
        if (x == anx) begin
          outcome.line_value = pwl_pkg::OUT_W'(val_at(base + lo + 1));
          outcome.status     = pwl_pkg::STAT_EXACT;
          return outcome;
        end
        if (x > alo && x < anx) begin
          a1 = alo;
          v1 = val_at(base + lo);
          a2 = anx;
          v2 = val_at(base + lo + 1);
          found = 1'b1;
          break;
        end
      end
      // An unordered table can leave the sample without an enclosing pair.
      if (!found) return outcome;
    end
    // Two points on the same ADC value give no line.
    if (a2 == a1) return outcome;
    // Exact 64-bit arithmetic; SystemVerilog division truncates toward zero.
    r = (x - a1) * (v2 - v1) / (a2 - a1) + v1;
    if (r < 0) r = 0;
    if (r > VALUE_CEIL) r = VALUE_CEIL;
    outcome.line_value = r[pwl_pkg::OUT_W-1:0];
    outcome.status     = pwl_pkg::STAT_INTERP;
    return outcome;
  endfunction

  // Apply one accepted request to the predictor state.
  function automatic void apply_request(pwl_request_t r);
    case (r.action)
      pwl_pkg::ACT_WRITE_POINT: begin
        if (r.channel < pwl_pkg::NUM_CHANNELS && r.point_index < pwl_pkg::MAX_POINTS)
          cal_points[r.channel * pwl_pkg::MAX_POINTS + r.point_index] =
            {r.point_value, r.point_ad};
      end
      pwl_pkg::ACT_SET_COUNT: begin
        // A count beyond the table size stores zero.
        if (r.channel < pwl_pkg::NUM_CHANNELS)
          cal_count[r.channel] = (r.point_count > pwl_pkg::MAX_POINTS) ? 4'd0 : r.point_count;
      end
      pwl_pkg::ACT_CONVERT: begin
        conversions_due.push_back(calibrate(r.channel, longint'(r.ad_sample)));
      end
      default: ;  // reserved action: dropped, no result
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request generation. The generator shadows which table entries have been
  // written so that no conversion ever scans an entry that was never written:
  // a point count is only set when entries 0..count-1 exist.
  // ---------------------------------------------------------------------------
  pwl_request_t                   request_backlog [$];
  logic [pwl_pkg::MAX_POINTS-1:0] gen_written [pwl_pkg::NUM_CHANNELS];
  int                             gen_ad      [pwl_pkg::TABLE_DEPTH];
  int                             gen_count   [pwl_pkg::NUM_CHANNELS];
  int                             useful_requests;
  int                             total_requests;
  bit                             drain_next;

  // Request with every field random; the caller fills the ones that matter.
  function automatic pwl_request_t scrambled_request(logic [pwl_pkg::ACT_W-1:0] act, int ch);
    pwl_request_t r;
    r.action      = act;
    r.channel     = pwl_pkg::CH_W'(ch);
    r.point_index = pwl_pkg::PIDX_W'($urandom);
    r.point_ad    = pwl_pkg::AD_W'($urandom);
    r.point_value = pwl_pkg::VAL_W'($urandom);
    r.point_count = pwl_pkg::PCNT_W'($urandom);
    r.ad_sample   = pwl_pkg::AD_W'($urandom);
    r.drain       = 1'b0;
    return r;
  endfunction

  function automatic void queue_request(pwl_request_t r);
    r.drain    = drain_next;
    drain_next = 1'b0;
    if (r.action == pwl_pkg::ACT_WRITE_POINT) begin
      gen_written[r.channel][r.point_index]                   = 1'b1;
      gen_ad[r.channel * pwl_pkg::MAX_POINTS + r.point_index] = int'(r.point_ad);
    end
    if (r.action == pwl_pkg::ACT_SET_COUNT)
      gen_count[r.channel] = (r.point_count > pwl_pkg::MAX_POINTS) ? 0 : int'(r.point_count);
    if (r.action != ACT_RESERVED) useful_requests++;
    request_backlog.push_back(r);
  endfunction

  function automatic void queue_write(int ch, int idx, int ad, int val);
    pwl_request_t r = scrambled_request(pwl_pkg::ACT_WRITE_POINT, ch);
    r.point_index = pwl_pkg::PIDX_W'(idx);
    r.point_ad    = pwl_pkg::AD_W'(ad);
    r.point_value = pwl_pkg::VAL_W'(val);
    queue_request(r);
  endfunction

  function automatic void queue_count(int ch, int cnt);
    pwl_request_t r = scrambled_request(pwl_pkg::ACT_SET_COUNT, ch);
    int           ready_points = 0;
    while (ready_points < pwl_pkg::MAX_POINTS && gen_written[ch][ready_points]) ready_points++;
    // Cut a count that would expose unwritten entries back to the written run.
    if (cnt >= 1 && cnt <= pwl_pkg::MAX_POINTS && cnt > ready_points) cnt = ready_points;
    r.point_count = pwl_pkg::PCNT_W'(cnt);
    queue_request(r);
  endfunction

  function automatic void queue_convert(int ch, int sample);
    pwl_request_t r = scrambled_request(pwl_pkg::ACT_CONVERT, ch);
    r.ad_sample = pwl_pkg::AD_W'(sample);
    queue_request(r);
  endfunction

  // Load a channel with an ascending table of random size and content.
  function automatic void program_channel(int ch);
    int n;
    int ad;
    n  = ($urandom_range(9) < 7) ? $urandom_range(1, 4)
                                 : $urandom_range(5, pwl_pkg::MAX_POINTS);
    ad = $urandom_range(0, 24000);
    for (int k = 0; k < n; k++) begin
      queue_write(ch, k, ad, $urandom_range(0, 65535));
      // Now and then repeat an ADC value to hit the degenerate pair.
      ad += ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 5000);
    end
    queue_count(ch, n);
  endfunction

  // Convert a sample aimed at the channel's current points.
  function automatic void queue_probe(int ch);
    int n    = gen_count[ch];
    int base = ch * pwl_pkg::MAX_POINTS;
    int k    = (n > 0) ? $urandom_range(0, n - 1) : 0;
    int last = (n > 0) ? n - 1 : 0;
    int sample;
    case ($urandom_range(7))
      0, 1:    sample = gen_ad[base + k];
      2, 3:    sample = (k < last) ? $urandom_range(gen_ad[base + k], gen_ad[base + k + 1])
                                   : $urandom_range(0, 65535);
      4:       sample = $urandom_range(0, gen_ad[base]);
      5:       sample = $urandom_range(gen_ad[base + last], 65535);
      6:       sample = $urandom_range(1) ? 65535 : 0;
      default: sample = $urandom_range(0, 65535);
    endcase
    queue_convert(ch, sample);
  endfunction

  // ---------------------------------------------------------------------------
  // Run status shared by the stimulus plan, driver, monitor and watchdog.
  // ---------------------------------------------------------------------------
  int req_accepted = 0;
  int mismatches   = 0;
  bit timed_out    = 1'b0;

  // ---------------------------------------------------------------------------
  // Clock and stimulus plan.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int  roll;
    bit  mid_drain_done;
    // Hold every input known from time zero.
    rst                = 1'b1;
    req_if.valid       = 1'b0;
    req_if.action      = pwl_pkg::ACT_WRITE_POINT;
    req_if.channel     = '0;
    req_if.point_index = '0;
    req_if.point_ad    = '0;
    req_if.point_value = '0;
    req_if.point_count = '0;
    req_if.ad_sample   = '0;
    res_if.ready       = 1'b0;
    for (int i = 0; i < pwl_pkg::TABLE_DEPTH; i++) begin
      cal_points[i] = '0;
      gen_ad[i]     = 0;
    end
    for (int c = 0; c < pwl_pkg::NUM_CHANNELS; c++) begin
      cal_count[c]   = '0;
      gen_written[c] = '0;
      gen_count[c]   = 0;
    end
    useful_requests = 0;
    drain_next      = 1'b0;
    mid_drain_done  = 1'b0;

    // Directed part.
    queue_convert(0, 1234);                 // empty table: error
    queue_write(1, 0, 1000, 500);           // single point through the origin
    queue_count(1, 1);
    queue_convert(1, 3000);
    queue_convert(1, 1000);                 // on the point, still interpolated
    queue_write(2, 0, 0, 65535);            // single point on ADC zero: no line
    queue_count(2, 1);
    queue_convert(2, 5);
    queue_write(3, 0, 0, 100);              // full-scale three point table
    queue_write(3, 1, 30000, 40000);
    queue_write(3, 2, 65535, 65535);
    queue_count(3, 3);
    queue_convert(3, 0);                    // exact on first, last, middle
    queue_convert(3, 65535);
    queue_convert(3, 30000);
    queue_convert(3, 15000);                // between points
    queue_write(4, 0, 100, 1000);           // falling line
    queue_write(4, 1, 200, 0);
    queue_count(4, 2);
    queue_convert(4, 65535);                // extrapolates negative: clamps to zero
    queue_convert(4, 50);                   // extrapolates below the table
    queue_count(5, 15);                     // oversize count stores zero
    queue_convert(5, 777);
    queue_request(scrambled_request(ACT_RESERVED,
                                    $urandom_range(0, pwl_pkg::NUM_CHANNELS - 1)));

    // Random part: mostly program-then-probe sequences, the rest noise that
    // overwrites points, changes counts and converts on arbitrary channels.
    drain_next = 1'b1;
    while (useful_requests < RANDOM_REQUESTS + 24) begin
      if (!mid_drain_done && useful_requests > RANDOM_REQUESTS / 2) begin
        drain_next     = 1'b1;
        mid_drain_done = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 25) begin
        program_channel($urandom_range(0, pwl_pkg::NUM_CHANNELS - 1));
      end else if (roll < 70) begin
        queue_probe($urandom_range(0, pwl_pkg::NUM_CHANNELS - 1));
      end else if (roll < 78) begin
        queue_write($urandom_range(0, pwl_pkg::NUM_CHANNELS - 1),
                    $urandom_range(0, pwl_pkg::MAX_POINTS - 1),
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
      end else if (roll < 85) begin
        queue_count($urandom_range(0, pwl_pkg::NUM_CHANNELS - 1), $urandom_range(0, 15));
      end else if (roll < 90) begin
        queue_request(scrambled_request(ACT_RESERVED,
                                        $urandom_range(0, pwl_pkg::NUM_CHANNELS - 1)));
      end else begin
        queue_convert($urandom_range(0, pwl_pkg::NUM_CHANNELS - 1), $urandom_range(0, 65535));
      end
    end
    total_requests = request_backlog.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to go in and every result to come back, then
    // give the block time to show any stray result.
    fork
      begin
        while (req_accepted != total_requests || conversions_due.size() != 0)
          @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
      end
      wait (timed_out);
    join_any
    if (!timed_out && mismatches == 0 && conversions_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Request driver: presents the backlog in order, with idle bursts between
  // requests and a hold on any request marked to wait for an empty pipeline.
  // ---------------------------------------------------------------------------
  pwl_request_t req_now;
  int           send_gap     = 0;
  int           idle_pct     = 20;
  bit           calm         = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      calm <= (request_backlog.size() < CALM_TAIL);
      if (req_if.valid && req_if.ready) begin
        apply_request(req_now);
        req_accepted++;
        // Change the idle rate now and then, zero included.
        if (req_accepted % 40 == 0) idle_pct = 20 * $urandom_range(2);
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (req_if.valid && !calm && $urandom_range(99) < idle_pct) begin
          // Start an idle burst, its length drawn into send_gap; this one counts as the first.
          send_gap = $urandom_range(3);
          req_if.valid <= 1'b0;
        end else if (request_backlog.size() > 0 &&
                     !(request_backlog[0].drain && conversions_due.size() > 0)) begin
          req_now = request_backlog.pop_front();
          req_if.valid       <= 1'b1;
          req_if.action      <= req_now.action;
          req_if.channel     <= req_now.channel;
          req_if.point_index <= req_now.point_index;
          req_if.point_ad    <= req_now.point_ad;
          req_if.point_value <= req_now.point_value;
          req_if.point_count <= req_now.point_count;
          req_if.ad_sample   <= req_now.ad_sample;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each result against the oldest expected conversion
  // and stalls the result channel in random bursts.
  // ---------------------------------------------------------------------------
  cal_result_t due;
  int          results_seen = 0;
  int          stall_left   = 0;
  int          stall_pct    = 20;

  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (results_seen % 16 == 0) stall_pct = 20 * $urandom_range(2);
        if (conversions_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got line_value %0d status %0d",
                   $time, res_if.line_value, res_if.status);
          mismatches++;
        end else begin
          due = conversions_due.pop_front();
          if (res_if.line_value !== due.line_value) begin
            $display("%0t: line_value mismatch, expected %0d, got %0d",
                     $time, due.line_value, res_if.line_value);
            mismatches++;
          end
          if (res_if.status !== due.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, due.status, res_if.status);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(3);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: flag a hang when neither channel moves for too long.
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      timed_out <= 1'b1;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
